### rtl/udpss_pkg.sv
// shared types, constants and helpers for the udp sample statistics reflector
// no dependencies
package udpss_pkg;

   localparam int COPIES_DEF   = 8;
   localparam int SUM_BITS_DEF = 32;

   localparam int BEAT_W      = 256;
   localparam int WORD_W      = 64;
   localparam int KEEP_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 32;
   localparam int MIN_W       = 17;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 2;

   localparam logic [47:0]       MAC_RESET     = 48'h248A07A8F9F6;
   localparam logic [31:0]       SRC_IP_RESET  = 32'hC0A80102;
   localparam logic [31:0]       DEST_IP_RESET = 32'hC0A80103;
   localparam logic [15:0]       PORT_RESET    = 16'd5001;
   localparam logic [MIN_W-1:0]  MIN_RESET     = 17'd99999;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REPLY_MAC     = 2'd0,
      CSR_REPLY_SRC_IP  = 2'd1,
      CSR_REPLY_DEST_IP = 2'd2,
      CSR_MATCH_PORT    = 2'd3
   } udpss_csr_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take_first;
      logic take_second;
      logic stat_update;
      logic div_start;
      logic send;
      logic beat_second;
      logic run_end;
   } udpss_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic port_match;
      logic div_done;
   } udpss_sts_type;

   function automatic logic [15:0] swap16(input logic [15:0] v);
      swap16 = {v[7:0], v[15:8]};
   endfunction

endpackage

### rtl/udp_sample_stats_reflector.sv
// udp sample statistics reflector: one item is one 256-bit beat, taken in pairs
// a matching pair is followed by the statistics update and a restoring divide (one quotient
// bit a cycle) before its first reply beat; the reply burst starts once the divider is done
// throughput: one beat per cycle while pairing, then 2 * COPIES reply transactions, each
// held while rsp_ready is low; no request beat is taken until the burst ends
// reset: synchronous, active high; configuration registers return to their defaults, statistics clear
module udp_sample_stats_reflector #(
   parameter int COPIES   = udpss_pkg::COPIES_DEF,   // reply pairs per matching packet
   parameter int SUM_BITS = udpss_pkg::SUM_BITS_DEF  // width of the saturating sum
) (
   input  logic                              clock,
   input  logic                              reset,

   // request stream
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word0,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word1,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word2,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word3,
   input  logic [udpss_pkg::KEEP_W-1:0]      req_beat_keep,
   input  logic                              req_beat_last,

   // reply stream
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word0,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word1,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word2,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word3,
   output logic [udpss_pkg::KEEP_W-1:0]      rsp_out_keep,
   output logic                              rsp_out_last,
   output logic                              rsp_run_end,

   // register write port
   input  logic                              csr_wr_en,
   input  logic [udpss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [udpss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   udpss_pkg::udpss_cmd_type cmd;
   udpss_pkg::udpss_sts_type sts;

   // controller: pairing, stats update, divide, burst sequencing
   udpss_ctrl #(
      .COPIES (COPIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: held beats, statistics, divider, reply rewrite
   udpss_datapath #(
      .SUM_BITS (SUM_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_valid      (req_valid),
      .req_beat_word0 (req_beat_word0),
      .req_beat_word1 (req_beat_word1),
      .req_beat_word2 (req_beat_word2),
      .req_beat_word3 (req_beat_word3),
      .req_beat_keep  (req_beat_keep),
      .req_beat_last  (req_beat_last),
      .rsp_out_word0  (rsp_out_word0),
      .rsp_out_word1  (rsp_out_word1),
      .rsp_out_word2  (rsp_out_word2),
      .rsp_out_word3  (rsp_out_word3),
      .rsp_out_keep   (rsp_out_keep),
      .rsp_out_last   (rsp_out_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ready only while waiting for either beat of a pair
   assign req_ready   = cmd.take_first | cmd.take_second;
   assign rsp_valid   = cmd.send;
   // run end flags the second beat of the final copy
   assign rsp_run_end = cmd.run_end;

endmodule

### rtl/udpss_div.sv
// iterative restoring divider, one quotient bit per cycle, low 16 quotient bits kept
// depends on udpss_pkg
module udpss_div #(
   parameter int DIVIDEND_W = udpss_pkg::SUM_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIVIDEND_W-1:0]          dividend,
   input  logic [udpss_pkg::COUNT_W-1:0]  divisor,
   output logic [udpss_pkg::SAMPLE_W-1:0] quotient,
   output logic                           done
);

   localparam int DW     = udpss_pkg::COUNT_W;
   localparam int QW     = udpss_pkg::SAMPLE_W;
   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DW-1:0]         rem_ff;
   logic [DW-1:0]         rem_in;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [QW-1:0]         quot_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DW:0]           trial;
   logic [DW:0]           diff;
   logic                  qbit;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, divisor};
      qbit   = (trial >= {1'b0, divisor});
      rem_in = qbit ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         dvd_ff  <= dividend;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         dvd_ff  <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QW-2:0], qbit};
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

### rtl/udpss_datapath.sv
// datapath: register file, held beats, running statistics, divider and reply assembly
// depends on udpss_pkg and udpss_div
module udpss_datapath #(
   parameter int SUM_BITS = udpss_pkg::SUM_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  udpss_pkg::udpss_cmd_type          cmd,
   output udpss_pkg::udpss_sts_type          sts,
   input  logic                              req_valid,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word0,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word1,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word2,
   input  logic [udpss_pkg::WORD_W-1:0]      req_beat_word3,
   input  logic [udpss_pkg::KEEP_W-1:0]      req_beat_keep,
   input  logic                              req_beat_last,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word0,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word1,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word2,
   output logic [udpss_pkg::WORD_W-1:0]      rsp_out_word3,
   output logic [udpss_pkg::KEEP_W-1:0]      rsp_out_keep,
   output logic                              rsp_out_last,
   input  logic                              csr_wr_en,
   input  logic [udpss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [udpss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BW = udpss_pkg::BEAT_W;
   localparam int SW = udpss_pkg::SAMPLE_W;
   localparam int CW = udpss_pkg::COUNT_W;
   localparam int MW = udpss_pkg::MIN_W;

   // configuration registers
   logic [47:0] mac_ff;
   logic [31:0] src_ip_ff;
   logic [31:0] dest_ip_ff;
   logic [15:0] port_ff;

   // held beats
   logic [BW-1:0]                first_ff;
   logic [udpss_pkg::KEEP_W-1:0] first_keep_ff;
   logic                         first_last_ff;
   logic [BW-1:0]                second_ff;
   logic [udpss_pkg::KEEP_W-1:0] second_keep_ff;
   logic                         second_last_ff;
   logic [SW-1:0]                sample_ff;

   // statistics
   logic [SUM_BITS-1:0] sum_ff;
   logic [SUM_BITS-1:0] sum_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [MW-1:0]       min_ff;
   logic [MW-1:0]       min_in;
   logic [SW-1:0]       max_ff;
   logic [SW-1:0]       max_in;
   logic [SUM_BITS:0]   sum_wide;

   logic [BW-1:0] req_beat;
   logic [BW-1:0] reply_first;
   logic [BW-1:0] reply_second;
   logic [BW-1:0] reply_beat;
   logic [SW-1:0] avg;
   logic          div_done;

   assign req_beat = {req_beat_word3, req_beat_word2, req_beat_word1, req_beat_word0};

   assign sts.port_match = (req_beat[223:208] == port_ff);
   assign sts.div_done   = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff     <= udpss_pkg::MAC_RESET;
         src_ip_ff  <= udpss_pkg::SRC_IP_RESET;
         dest_ip_ff <= udpss_pkg::DEST_IP_RESET;
         port_ff    <= udpss_pkg::PORT_RESET;
      end else if (csr_wr_en) begin
         case (udpss_pkg::udpss_csr_type'(csr_index))
            udpss_pkg::CSR_REPLY_MAC:     mac_ff     <= csr_wdata[47:0];
            udpss_pkg::CSR_REPLY_SRC_IP:  src_ip_ff  <= csr_wdata[31:0];
            udpss_pkg::CSR_REPLY_DEST_IP: dest_ip_ff <= csr_wdata[31:0];
            udpss_pkg::CSR_MATCH_PORT:    port_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && cmd.take_first) begin
         first_ff      <= req_beat;
         first_keep_ff <= req_beat_keep;
         first_last_ff <= req_beat_last;
      end
      if (req_valid && cmd.take_second) begin
         second_ff      <= {req_beat[255:192], 16'h0000, req_beat[175:0]};
         second_keep_ff <= req_beat_keep;
         second_last_ff <= req_beat_last;
         sample_ff      <= udpss_pkg::swap16(req_beat[175:160]);
      end
   end

   // saturating sum and count, running extremes
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_BITS+1)'(sample_ff);
      sum_in   = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
      count_in = (count_ff == {CW{1'b1}}) ? count_ff : count_ff + 1'b1;
      min_in   = (min_ff > MW'(sample_ff)) ? MW'(sample_ff) : min_ff;
      max_in   = (max_ff < sample_ff) ? sample_ff : max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         min_ff   <= udpss_pkg::MIN_RESET;
         max_ff   <= '0;
      end else if (cmd.stat_update) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   udpss_div #(
      .DIVIDEND_W (SUM_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (avg),
      .done     (div_done)
   );

   // reply assembly
   always_comb begin
      reply_first           = first_ff;
      reply_first[255:208]  = mac_ff;
      reply_first[47:16]    = src_ip_ff;
      reply_first[15:0]     = dest_ip_ff[31:16];

      reply_second          = second_ff;
      reply_second[255:240] = dest_ip_ff[15:0];
      reply_second[159:144] = udpss_pkg::swap16(avg);
      reply_second[143:128] = udpss_pkg::swap16(max_ff);
      reply_second[127:112] = udpss_pkg::swap16(min_ff[SW-1:0]);
      reply_second[111:96]  = udpss_pkg::swap16(count_ff[SW-1:0]);

      reply_beat = cmd.beat_second ? reply_second : reply_first;
   end

   assign rsp_out_word0 = reply_beat[63:0];
   assign rsp_out_word1 = reply_beat[127:64];
   assign rsp_out_word2 = reply_beat[191:128];
   assign rsp_out_word3 = reply_beat[255:192];
   assign rsp_out_keep  = cmd.beat_second ? second_keep_ff : first_keep_ff;
   assign rsp_out_last  = cmd.beat_second ? second_last_ff : first_last_ff;

endmodule

### rtl/udpss_ctrl.sv
// controller: pairs beats, sequences statistics update, division and reply burst
// depends on udpss_pkg
module udpss_ctrl #(
   parameter int COPIES = udpss_pkg::COPIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     rsp_ready,
   input  udpss_pkg::udpss_sts_type sts,
   output udpss_pkg::udpss_cmd_type cmd
);

   localparam int CNT_W = (COPIES > 1) ? $clog2(COPIES) : 1;

   // idle command word: waiting for the first beat of a pair
   localparam udpss_pkg::udpss_cmd_type CMD_TAKE_FIRST = '{take_first: 1'b1, default: 1'b0};

   typedef enum logic [2:0] {
      ST_FIRST,
      ST_SECOND,
      ST_STATS,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type                state_ff;
   udpss_pkg::udpss_cmd_type cmd_ff;
   logic [CNT_W-1:0]         copy_ff;
   logic                     last_copy;

   assign last_copy = (copy_ff == CNT_W'(COPIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FIRST;
         cmd_ff   <= CMD_TAKE_FIRST;
         copy_ff  <= '0;
      end else begin
         case (state_ff)
            ST_FIRST: begin
               if (req_valid) begin
                  state_ff           <= ST_SECOND;
                  cmd_ff.take_first  <= 1'b0;
                  cmd_ff.take_second <= 1'b1;
               end
            end
            ST_SECOND: begin
               if (req_valid) begin
                  cmd_ff.take_second <= 1'b0;
                  if (sts.port_match) begin
                     state_ff           <= ST_STATS;
                     cmd_ff.stat_update <= 1'b1;
                  end else begin
                     state_ff          <= ST_FIRST;
                     cmd_ff.take_first <= 1'b1;
                  end
               end
            end
            ST_STATS: begin
               state_ff           <= ST_DIV;
               cmd_ff.stat_update <= 1'b0;
               cmd_ff.div_start   <= 1'b1;
            end
            ST_DIV: begin
               cmd_ff.div_start <= 1'b0;
               if (sts.div_done) begin
                  state_ff           <= ST_SEND;
                  cmd_ff.send        <= 1'b1;
                  cmd_ff.beat_second <= 1'b0;
                  cmd_ff.run_end     <= 1'b0;
                  copy_ff            <= '0;
               end
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  if (!cmd_ff.beat_second) begin
                     cmd_ff.beat_second <= 1'b1;
                     cmd_ff.run_end     <= last_copy;
                  end else if (last_copy) begin
                     state_ff           <= ST_FIRST;
                     cmd_ff.send        <= 1'b0;
                     cmd_ff.beat_second <= 1'b0;
                     cmd_ff.run_end     <= 1'b0;
                     cmd_ff.take_first  <= 1'b1;
                  end else begin
                     copy_ff            <= copy_ff + 1'b1;
                     cmd_ff.beat_second <= 1'b0;
                     cmd_ff.run_end     <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_FIRST;
               cmd_ff   <= CMD_TAKE_FIRST;
            end
         endcase
      end
   end

   assign cmd = cmd_ff;

endmodule
